// ----- design/exponential_soft_clip_distortion_macros.svh -----
// Assertion macros shared by the soft clip distortion block
`ifndef EXPONENTIAL_SOFT_CLIP_DISTORTION_MACROS_SVH
`define EXPONENTIAL_SOFT_CLIP_DISTORTION_MACROS_SVH

// same-cycle implication, checked outside reset
`define ESC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("soft clip pipeline check failed");

// next-cycle implication, checked outside reset
`define ESC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("soft clip pipeline check failed");

`endif

// ----- design/esc_pkg.sv -----
// Shared types, constants and table functions of the soft clip distortion block
`timescale 1ns / 1ps

package esc_pkg;

   localparam int SAMPLE_W           = 16;
   localparam int CHANNEL_W          = 3;
   localparam int GAIN_W             = 16;
   localparam int MIX_W              = 16;
   localparam int CSR_ADDR_W         = 3;
   localparam int CSR_DATA_W         = 32;
   localparam int EXP_TABLE_BITS_DEF = 8;
   localparam int T_BITS             = 12;
   localparam int MAG_W              = 31;
   localparam int MAG_SAT_BIT        = 27;
   localparam int EXP_W              = 25;
   localparam int Z_W                = 26;
   localparam int PIPE_STAGES        = 6;

   localparam logic [63:0] ONE_Q24 = 64'd16777216;

   // register index, taken from paddr[2]
   localparam logic REG_DRIVE_GAIN = 1'b0;
   localparam logic REG_WET_MIX    = 1'b1;

   localparam logic [GAIN_W-1:0] DRIVE_GAIN_RESET = 16'd0;
   localparam logic [MIX_W-1:0]  WET_MIX_RESET    = 16'd32768;

   typedef struct packed {
      logic [CHANNEL_W-1:0] channel;
      logic                 last;
   } esc_meta_type;

   // exp(-2^(b-8)) in Q0.24
   function automatic logic [23:0] exp_pow(input int unsigned b);
      logic [23:0] v;
      begin
         case (b)
            0:       v = 24'd16711808;
            1:       v = 24'd16646655;
            2:       v = 24'd16517109;
            3:       v = 24'd16261035;
            4:       v = 24'd15760736;
            5:       v = 24'd14805841;
            6:       v = 24'd13066109;
            7:       v = 24'd10175896;
            8:       v = 24'd6171993;
            9:       v = 24'd2270549;
            10:      v = 24'd307285;
            11:      v = 24'd5628;
            default: v = 24'd0;
         endcase
         return v;
      end
   endfunction

   // table point k of exp(-t), spacing 16 / 2^tb, built from the power constants
   function automatic logic [EXP_W-1:0] exp_point(input int unsigned k, input int unsigned tb);
      logic [63:0]       acc;
      logic [T_BITS-1:0] t_units;
      begin
         acc = ONE_Q24;
         if (k >= (32'd1 << tb)) begin
            return '0;
         end
         t_units = T_BITS'(k << (T_BITS - tb));
         for (int b = 0; b < T_BITS; b++) begin
            if (t_units[b]) begin
               acc = (acc * 64'(exp_pow(b)) + (ONE_Q24 >> 1)) >> 24;
            end
         end
         return acc[EXP_W-1:0];
      end
   endfunction

endpackage

// ----- design/esc_csr.sv -----
// Configuration register file: drive gain and wet mix behind an APB-style port
`timescale 1ns / 1ps

module esc_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [esc_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [esc_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [esc_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready,
   output logic [esc_pkg::GAIN_W-1:0]      drive_gain,
   output logic [esc_pkg::MIX_W-1:0]       wet_mix
);
   import esc_pkg::*;

   logic [GAIN_W-1:0] gain_ff, gain_in;
   logic [MIX_W-1:0]  wet_ff, wet_in;
   logic              wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      gain_in = gain_ff;
      wet_in  = wet_ff;
      if (wr_en) begin
         case (paddr[2])
            REG_DRIVE_GAIN: gain_in = pwdata[GAIN_W-1:0];
            REG_WET_MIX:    wet_in  = pwdata[MIX_W-1:0];
            default:        gain_in = gain_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= DRIVE_GAIN_RESET;
         wet_ff  <= WET_MIX_RESET;
      end else begin
         gain_ff <= gain_in;
         wet_ff  <= wet_in;
      end
   end

   always_comb begin
      case (paddr[2])
         REG_DRIVE_GAIN: prdata = CSR_DATA_W'(gain_ff);
         REG_WET_MIX:    prdata = CSR_DATA_W'(wet_ff);
         default:        prdata = '0;
      endcase
   end

   assign drive_gain = gain_ff;
   assign wet_mix    = wet_ff;

endmodule

// ----- design/esc_gain.sv -----
// Drive stage: magnitude of the sample times the Q8.8 drive gain
`timescale 1ns / 1ps

module esc_gain (
   input  logic                                  clock,
   input  logic                                  en,
   input  logic signed [esc_pkg::SAMPLE_W-1:0]   x,
   input  esc_pkg::esc_meta_type                 meta,
   input  logic [esc_pkg::GAIN_W-1:0]            drive_gain,
   output logic [esc_pkg::MAG_W-1:0]             mag,
   output logic signed [esc_pkg::SAMPLE_W-1:0]   x_out,
   output esc_pkg::esc_meta_type                 meta_out
);
   import esc_pkg::*;

   logic [SAMPLE_W-1:0]        ax;
   logic [MAG_W-1:0]           mag_ff, mag_in;
   logic signed [SAMPLE_W-1:0] x_ff;
   esc_meta_type               meta_ff;

   // -(-32768) wraps to 0x8000, which is the right unsigned magnitude
   assign ax     = x[SAMPLE_W-1] ? SAMPLE_W'(-x) : SAMPLE_W'(x);
   assign mag_in = MAG_W'(32'(ax) * 32'(drive_gain));

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff  <= mag_in;
         x_ff    <= x;
         meta_ff <= meta;
      end
   end

   assign mag      = mag_ff;
   assign x_out    = x_ff;
   assign meta_out = meta_ff;

endmodule

// ----- design/esc_shaper.sv -----
// Shaper: exp table read, linear interpolation and signed 1 - exp(-|q|)
`timescale 1ns / 1ps

module esc_shaper #(
   parameter int EXP_TABLE_BITS = esc_pkg::EXP_TABLE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic [2:0]                            en,
   input  logic [esc_pkg::MAG_W-1:0]             mag,
   input  logic signed [esc_pkg::SAMPLE_W-1:0]   x,
   input  esc_pkg::esc_meta_type                 meta,
   output logic signed [esc_pkg::Z_W-1:0]        z,
   output logic signed [esc_pkg::SAMPLE_W-1:0]   x_out,
   output esc_pkg::esc_meta_type                 meta_out
);
   import esc_pkg::*;

   localparam int TB     = EXP_TABLE_BITS;
   localparam int FB     = MAG_SAT_BIT - TB;
   localparam int PROD_W = EXP_W + FB;
   localparam int DEPTH  = 2 ** TB;

   logic [EXP_W-1:0] exp_tbl [DEPTH];

   for (genvar g = 0; g < DEPTH; g++) begin : g_tbl
      localparam logic [EXP_W-1:0] POINT = exp_point(g, TB);
      assign exp_tbl[g] = POINT;
   end

   // table read
   logic [TB-1:0]              k, k_next;
   logic [FB-1:0]              frac_in;
   logic                       sat_in;
   logic [EXP_W-1:0]           e0_in, e1_in;
   logic [EXP_W-1:0]           e0_ff, e1_ff;
   logic [FB-1:0]              frac_ff;
   logic                       sat_ff;
   logic signed [SAMPLE_W-1:0] x1_ff;
   esc_meta_type               meta1_ff;

   assign k       = mag[MAG_SAT_BIT-1:FB];
   assign k_next  = k + TB'(1);
   assign frac_in = mag[FB-1:0];
   assign sat_in  = |mag[MAG_W-1:MAG_SAT_BIT];
   assign e0_in   = exp_tbl[k];
   // the point past the last entry is exp(-16), taken as zero
   assign e1_in   = (&k) ? '0 : exp_tbl[k_next];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         e0_ff    <= e0_in;
         e1_ff    <= e1_in;
         frac_ff  <= frac_in;
         sat_ff   <= sat_in;
         x1_ff    <= x;
         meta1_ff <= meta;
      end
   end

   // interpolation product
   logic [EXP_W-1:0]           diff;
   logic [PROD_W-1:0]          prod_in, prod_ff;
   logic [EXP_W-1:0]           e0_2_ff;
   logic                       sat2_ff;
   logic signed [SAMPLE_W-1:0] x2_ff;
   esc_meta_type               meta2_ff;

   assign diff    = e0_ff - e1_ff;
   assign prod_in = PROD_W'(diff) * PROD_W'(frac_ff);

   always_ff @(posedge clock) begin
      if (en[1]) begin
         prod_ff  <= prod_in;
         e0_2_ff  <= e0_ff;
         sat2_ff  <= sat_ff;
         x2_ff    <= x1_ff;
         meta2_ff <= meta1_ff;
      end
   end

   // round the step, subtract, shape and apply the sign
   logic [PROD_W:0]            rnd_sum;
   logic [EXP_W-1:0]           step;
   logic [EXP_W-1:0]           e_val;
   logic signed [Z_W-1:0]      z_mag, z_in, z_ff;
   logic signed [SAMPLE_W-1:0] x3_ff;
   esc_meta_type               meta3_ff;

   assign rnd_sum = (PROD_W+1)'(prod_ff) + ((PROD_W+1)'(1) << (FB - 1));
   assign step    = rnd_sum[FB +: EXP_W];
   assign e_val   = sat2_ff ? '0 : (e0_2_ff - step);
   assign z_mag   = Z_W'(ONE_Q24) - signed'(Z_W'(e_val));
   assign z_in    = x2_ff[SAMPLE_W-1] ? -z_mag : z_mag;

   always_ff @(posedge clock) begin
      if (en[2]) begin
         z_ff     <= z_in;
         x3_ff    <= x2_ff;
         meta3_ff <= meta2_ff;
      end
   end

   assign z        = z_ff;
   assign x_out    = x3_ff;
   assign meta_out = meta3_ff;

endmodule

// ----- design/esc_mix.sv -----
// Wet/dry mix with half-up rounding and saturation to Q1.15
`timescale 1ns / 1ps

module esc_mix (
   input  logic                                  clock,
   input  logic [1:0]                            en,
   input  logic signed [esc_pkg::Z_W-1:0]        z,
   input  logic signed [esc_pkg::SAMPLE_W-1:0]   x,
   input  esc_pkg::esc_meta_type                 meta,
   input  logic [esc_pkg::MIX_W-1:0]             wet_mix,
   output logic signed [esc_pkg::SAMPLE_W-1:0]   y,
   output esc_pkg::esc_meta_type                 meta_out
);
   import esc_pkg::*;

   localparam int W_W   = MIX_W + 1;
   localparam int WP_W  = W_W + Z_W;
   localparam int XS_W  = SAMPLE_W + 9;
   localparam int DP_W  = W_W + XS_W;
   localparam int ACC_W = WP_W + 1;
   localparam int Y_W   = ACC_W - 24;

   logic signed [W_W-1:0]  wet_s, dry_s;
   logic signed [XS_W-1:0] x_sh;
   logic signed [WP_W-1:0] wp_in, wp_ff;
   logic signed [DP_W-1:0] dp_in, dp_ff;
   esc_meta_type           meta1_ff;

   assign wet_s = signed'({1'b0, wet_mix});
   // a wet share above one makes the dry weight negative
   assign dry_s = signed'(W_W'(32768)) - wet_s;
   assign x_sh  = signed'({x, 9'b0});
   assign wp_in = WP_W'(wet_s) * WP_W'(z);
   assign dp_in = DP_W'(dry_s) * DP_W'(x_sh);

   always_ff @(posedge clock) begin
      if (en[0]) begin
         wp_ff    <= wp_in;
         dp_ff    <= dp_in;
         meta1_ff <= meta;
      end
   end

   logic signed [ACC_W-1:0]    acc, biased;
   logic signed [Y_W-1:0]      y_wide;
   logic signed [SAMPLE_W-1:0] y_in, y_ff;
   esc_meta_type               meta2_ff;

   assign acc    = ACC_W'(wp_ff) + ACC_W'(dp_ff);
   assign biased = acc + signed'(ACC_W'(1) << 23);
   assign y_wide = Y_W'(biased >>> 24);

   always_comb begin
      if (y_wide > signed'(Y_W'(32767))) begin
         y_in = 16'sh7FFF;
      end else if (y_wide < -signed'(Y_W'(32768))) begin
         y_in = -16'sh8000;
      end else begin
         y_in = SAMPLE_W'(y_wide);
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         y_ff     <= y_in;
         meta2_ff <= meta1_ff;
      end
   end

   assign y        = y_ff;
   assign meta_out = meta2_ff;

endmodule

// ----- design/exponential_soft_clip_distortion.sv -----
// Exponential soft clip waveshaper with wet/dry mix, six-stage pipeline.
// An accepted request passes through the gain, shaper and mix stages to the response.
// Throughput: one sample per cycle when not stalled; a stalled response holds its
// stage and the stages behind it fill their bubbles before the request side stalls.
// Reset (synchronous, active high) empties the pipeline and sets drive_gain
// to 0 and wet_mix to 32768 (fully wet).
`timescale 1ns / 1ps
`include "exponential_soft_clip_distortion_macros.svh"

module exponential_soft_clip_distortion #(
   parameter int EXP_TABLE_BITS = esc_pkg::EXP_TABLE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [esc_pkg::SAMPLE_W-1:0]   req_sample_in,
   input  logic [esc_pkg::CHANNEL_W-1:0]         req_channel_tag,
   input  logic                                  req_block_end,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [esc_pkg::SAMPLE_W-1:0]   rsp_sample_out,
   output logic [esc_pkg::CHANNEL_W-1:0]         rsp_channel_out,
   output logic                                  rsp_block_end_out,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [esc_pkg::CSR_ADDR_W-1:0]        paddr,
   input  logic [esc_pkg::CSR_DATA_W-1:0]        pwdata,
   output logic [esc_pkg::CSR_DATA_W-1:0]        prdata,
   output logic                                  pready
);
   import esc_pkg::*;

   logic [GAIN_W-1:0] drive_gain;
   logic [MIX_W-1:0]  wet_mix;

   esc_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .drive_gain (drive_gain),
      .wet_mix    (wet_mix)
   );

   // stage valid bits and per-stage advance
   logic [PIPE_STAGES-1:0] valid_ff, valid_in, adv;

   always_comb begin
      adv[PIPE_STAGES-1] = !valid_ff[PIPE_STAGES-1] || rsp_ready;
      for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
      valid_in[0] = adv[0] ? req_valid : valid_ff[0];
      for (int i = 1; i < PIPE_STAGES; i++) begin
         valid_in[i] = adv[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = adv[0];
   assign rsp_valid = valid_ff[PIPE_STAGES-1];

   esc_meta_type               req_meta, g_meta, s_meta, m_meta;
   logic [MAG_W-1:0]           g_mag;
   logic signed [SAMPLE_W-1:0] g_x, s_x, m_y;
   logic signed [Z_W-1:0]      s_z;

   assign req_meta.channel = req_channel_tag;
   assign req_meta.last    = req_block_end;

   esc_gain u_gain (
      .clock      (clock),
      .en         (adv[0]),
      .x          (req_sample_in),
      .meta       (req_meta),
      .drive_gain (drive_gain),
      .mag        (g_mag),
      .x_out      (g_x),
      .meta_out   (g_meta)
   );

   esc_shaper #(
      .EXP_TABLE_BITS (EXP_TABLE_BITS)
   ) u_shaper (
      .clock    (clock),
      .en       (adv[3:1]),
      .mag      (g_mag),
      .x        (g_x),
      .meta     (g_meta),
      .z        (s_z),
      .x_out    (s_x),
      .meta_out (s_meta)
   );

   esc_mix u_mix (
      .clock    (clock),
      .en       (adv[5:4]),
      .z        (s_z),
      .x        (s_x),
      .meta     (s_meta),
      .wet_mix  (wet_mix),
      .y        (m_y),
      .meta_out (m_meta)
   );

   assign rsp_sample_out    = m_y;
   assign rsp_channel_out   = m_meta.channel;
   assign rsp_block_end_out = m_meta.last;

   `ESC_ASSERT_NEXT(a_accept_enters, clock, reset, req_valid && req_ready, valid_ff[0])
   `ESC_ASSERT_NOW(a_full_stalls, clock, reset, (&valid_ff) && !rsp_ready, !req_ready)
   `ESC_ASSERT_NEXT(a_drain_empties, clock, reset,
      valid_ff[PIPE_STAGES-1] && rsp_ready && !valid_ff[PIPE_STAGES-2], !rsp_valid)

endmodule
